@@ rtl/core/c3ce_pkg.sv @@
package c3ce_pkg;

    // frame geometry
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int KSIZE      = 3;
    localparam int NTAPS      = KSIZE * KSIZE;

    localparam int DIM_W      = 11;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int OUT_RC_W   = 10;

    // data widths
    localparam int PIX_W      = 8;
    localparam int COEF_W     = 16;
    localparam int KROW_W     = KSIZE * COEF_W;
    localparam int PROD_W     = PIX_W + COEF_W;
    localparam int RSUM_W     = PROD_W + 2;
    localparam int VAL_W      = 28;
    localparam int LS_W       = 2 * PIX_W;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = KROW_W;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KROW_TOP   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KROW_MID   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_KROW_BOT   = 3'd4;

    // result kinds, in emission order
    localparam int NUM_KIND          = 4;
    localparam int KIND_ABOVE        = 0;
    localparam int KIND_ABOVE_RIGHT  = 1;
    localparam int KIND_BOTTOM       = 2;
    localparam int KIND_BOTTOM_RIGHT = 3;

    typedef logic [PIX_W-1:0]                   t_pix;
    typedef t_pix [KSIZE-1:0][KSIZE-1:0]        t_win;
    typedef t_pix [NTAPS-1:0]                   t_taps;
    typedef logic [KSIZE-1:0][KROW_W-1:0]       t_krows;
    typedef logic [NUM_KIND-1:0]                t_kmask;

    typedef struct packed {
        logic [OUT_RC_W-1:0] row;
        logic [OUT_RC_W-1:0] col;
        logic                run_last;
        logic                frame_last;
    } t_meta;

    typedef struct packed {
        t_taps taps;
        t_meta meta;
    } t_issue;

endpackage

@@ rtl/core/c3ce_ram.sv @@
module c3ce_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // write-first on a same-address collision
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            if (i_we && (i_waddr == i_raddr)) begin
                r_rdata <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_raddr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/c3ce_front.sv @@
module c3ce_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  c3ce_pkg::t_pix              i_pixel,
    input  logic [c3ce_pkg::DIM_W-1:0]  i_width,
    input  logic [c3ce_pkg::DIM_W-1:0]  i_height,
    output logic                        o_iss_valid,
    input  logic                        i_iss_ready,
    output c3ce_pkg::t_issue            o_iss
);
    import c3ce_pkg::*;

    localparam logic [DIM_W-1:0] W_MAX = DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0] H_MAX = DIM_W'(MAX_HEIGHT);
    localparam logic [DIM_W-1:0] DIM_MIN = DIM_W'(2);

    // frame position
    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;

    // stage a: waiting for the line store read
    logic             r_a_v;
    t_pix             r_a_pix;
    logic [COL_W-1:0] r_a_c, r_a_cm1;
    logic [ROW_W-1:0] r_a_r, r_a_rm1;
    logic             r_a_ge1, r_a_ge2, r_a_odd;
    t_kmask           r_a_mask;

    // stage b: result sequencer over the window
    t_win             r_win;
    logic             r_b_v;
    t_kmask           r_b_mask;
    logic [COL_W-1:0] r_b_c, r_b_cm1;
    logic [ROW_W-1:0] r_b_r, r_b_rm1;

    logic [DIM_W-1:0] w, h;
    logic             wrap_col, c_last, r_last, c_ge1, r_ge1;
    logic [ROW_W:0]   rr_ext;
    logic [COL_W-1:0] cc;
    logic [ROW_W-1:0] rr;
    t_kmask           mask;

    logic             acc, a_adv, b_fire, b_last, b_free;
    logic [LS_W-1:0]  rd_word, wr_word;
    t_pix             bank0, bank1, mid, top;
    t_pix [KSIZE-1:0] nv;
    t_kmask           pick, rest;
    logic             bot, right;

    // size in use, clamped to the supported range
    always_comb begin
        w = i_width;
        if (i_width < DIM_MIN) w = DIM_MIN;
        if (i_width > W_MAX)   w = W_MAX;
        h = i_height;
        if (i_height < DIM_MIN) h = DIM_MIN;
        if (i_height > H_MAX)   h = H_MAX;
    end

    always_comb begin
        wrap_col = (DIM_W'(r_col) >= w);
        cc       = wrap_col ? '0 : r_col;
        rr_ext   = {1'b0, r_row} + (ROW_W+1)'(wrap_col);
        rr       = (DIM_W'(rr_ext) >= h) ? '0 : rr_ext[ROW_W-1:0];
        c_last   = (DIM_W'(cc) == (w - DIM_W'(1)));
        r_last   = (DIM_W'(rr) == (h - DIM_W'(1)));
        c_ge1    = (cc != '0);
        r_ge1    = (rr != '0);
        mask[KIND_ABOVE]        = r_ge1 && c_ge1;
        mask[KIND_ABOVE_RIGHT]  = r_ge1 && c_last;
        mask[KIND_BOTTOM]       = r_last && c_ge1;
        mask[KIND_BOTTOM_RIGHT] = r_last && c_last;
        if (c_last) begin
            n_col = '0;
            n_row = r_last ? '0 : rr + ROW_W'(1);
        end else begin
            n_col = cc + COL_W'(1);
            n_row = rr;
        end
    end

    // handshakes between stages
    always_comb begin
        rest   = r_b_mask & (r_b_mask - t_kmask'(1));
        pick   = r_b_mask & ~rest;
        b_last = (rest == '0);
        b_fire = r_b_v && i_iss_ready;
        b_free = !r_b_v || (b_fire && b_last);
        a_adv  = r_a_v && b_free;
        o_in_ready = !r_a_v || b_free;
        acc    = i_in_valid && o_in_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_a_v <= 1'b0;
        end else begin
            if (acc) begin
                r_col <= n_col;
                r_row <= n_row;
                r_a_v <= 1'b1;
            end else if (a_adv) begin
                r_a_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_a_pix  <= i_pixel;
            r_a_c    <= cc;
            r_a_cm1  <= cc - COL_W'(1);
            r_a_r    <= rr;
            r_a_rm1  <= rr - ROW_W'(1);
            r_a_ge1  <= r_ge1;
            r_a_ge2  <= (rr > ROW_W'(1));
            r_a_odd  <= rr[0];
            r_a_mask <= mask;
        end
    end

    // two rows per line store word, bank chosen by row parity
    c3ce_ram #(
        .DEPTH (MAX_WIDTH),
        .WIDTH (LS_W)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (a_adv),
        .i_waddr (r_a_c),
        .i_wdata (wr_word),
        .i_re    (acc),
        .i_raddr (cc),
        .o_rdata (rd_word)
    );

    always_comb begin
        bank0 = rd_word[PIX_W-1:0];
        bank1 = rd_word[LS_W-1:PIX_W];
        mid   = r_a_ge1 ? (r_a_odd ? bank0 : bank1) : r_a_pix;
        top   = r_a_ge2 ? (r_a_odd ? bank1 : bank0) : mid;
        wr_word = r_a_odd ? {r_a_pix, bank0} : {bank1, r_a_pix};
        nv[0] = top;
        nv[1] = mid;
        nv[2] = r_a_pix;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (a_adv) begin
            for (int i = 0; i < KSIZE; i++) begin
                if (r_a_c == '0) begin
                    for (int j = 0; j < KSIZE; j++) begin
                        r_win[i][j] <= nv[i];
                    end
                end else begin
                    for (int j = 0; j < KSIZE - 1; j++) begin
                        r_win[i][j] <= r_win[i][j+1];
                    end
                    r_win[i][KSIZE-1] <= nv[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v    <= 1'b0;
            r_b_mask <= '0;
        end else begin
            if (a_adv) begin
                r_b_v    <= |r_a_mask;
                r_b_mask <= r_a_mask;
            end else if (b_fire) begin
                r_b_v    <= !b_last;
                r_b_mask <= rest;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_adv) begin
            r_b_c   <= r_a_c;
            r_b_cm1 <= r_a_cm1;
            r_b_r   <= r_a_r;
            r_b_rm1 <= r_a_rm1;
        end
    end

    // neighbourhood for the picked kind; edges repeat the border pixel
    always_comb begin
        int ra;
        int cb;
        bot   = pick[KIND_BOTTOM] || pick[KIND_BOTTOM_RIGHT];
        right = pick[KIND_ABOVE_RIGHT] || pick[KIND_BOTTOM_RIGHT];
        for (int a = 0; a < KSIZE; a++) begin
            for (int b = 0; b < KSIZE; b++) begin
                ra = bot ? ((a == 0) ? 1 : 2) : a;
                cb = right ? ((b == 0) ? 1 : 2) : b;
                o_iss.taps[a*KSIZE + b] = r_win[ra][cb];
            end
        end
        o_iss.meta.row        = bot ? OUT_RC_W'(r_b_r) : OUT_RC_W'(r_b_rm1);
        o_iss.meta.col        = right ? OUT_RC_W'(r_b_c) : OUT_RC_W'(r_b_cm1);
        o_iss.meta.run_last   = b_last;
        o_iss.meta.frame_last = pick[KIND_BOTTOM_RIGHT];
        o_iss_valid = r_b_v;
    end

endmodule

@@ rtl/core/c3ce_mac.sv @@
module c3ce_mac (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_iss_valid,
    output logic                          o_iss_ready,
    input  c3ce_pkg::t_issue              i_iss,
    input  c3ce_pkg::t_krows              i_krows,
    output logic                          o_valid,
    input  logic                          i_ready,
    output c3ce_pkg::t_meta               o_meta,
    output logic signed [c3ce_pkg::VAL_W-1:0] o_value
);
    import c3ce_pkg::*;

    logic                     r_c_v, r_d_v, r_e_v;
    t_meta                    r_c_meta, r_d_meta, r_e_meta;
    logic signed [PROD_W-1:0] r_c_prod [NTAPS];
    logic signed [RSUM_W-1:0] r_d_sum [KSIZE];
    logic signed [VAL_W-1:0]  r_e_value;

    logic signed [PROD_W-1:0] n_prod [NTAPS];
    logic signed [RSUM_W-1:0] n_sum [KSIZE];
    logic signed [VAL_W-1:0]  n_value;
    logic                     c_rdy, d_rdy, e_rdy;

    always_comb begin
        e_rdy = !r_e_v || i_ready;
        d_rdy = !r_d_v || e_rdy;
        c_rdy = !r_c_v || d_rdy;
        o_iss_ready = c_rdy;
    end

    // pixel times signed coefficient, one product per tap
    always_comb begin
        logic signed [PROD_W-1:0] pe;
        logic signed [PROD_W-1:0] ce;
        logic        [COEF_W-1:0] coef;
        for (int a = 0; a < KSIZE; a++) begin
            for (int b = 0; b < KSIZE; b++) begin
                coef = i_krows[a][b*COEF_W +: COEF_W];
                pe   = {{(PROD_W-PIX_W){1'b0}}, i_iss.taps[a*KSIZE + b]};
                ce   = {{(PROD_W-COEF_W){coef[COEF_W-1]}}, coef};
                n_prod[a*KSIZE + b] = pe * ce;
            end
        end
    end

    always_comb begin
        for (int a = 0; a < KSIZE; a++) begin
            n_sum[a] = RSUM_W'(r_c_prod[a*KSIZE]) + RSUM_W'(r_c_prod[a*KSIZE + 1])
                     + RSUM_W'(r_c_prod[a*KSIZE + 2]);
        end
        n_value = VAL_W'(r_d_sum[0]) + VAL_W'(r_d_sum[1]) + VAL_W'(r_d_sum[2]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
            r_e_v <= 1'b0;
        end else begin
            if (c_rdy) r_c_v <= i_iss_valid;
            if (d_rdy) r_d_v <= r_c_v;
            if (e_rdy) r_e_v <= r_d_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_iss_valid && c_rdy) begin
            r_c_meta <= i_iss.meta;
            for (int k = 0; k < NTAPS; k++) begin
                r_c_prod[k] <= n_prod[k];
            end
        end
        if (r_c_v && d_rdy) begin
            r_d_meta <= r_c_meta;
            for (int a = 0; a < KSIZE; a++) begin
                r_d_sum[a] <= n_sum[a];
            end
        end
        if (r_d_v && e_rdy) begin
            r_e_meta  <= r_d_meta;
            r_e_value <= n_value;
        end
    end

    assign o_valid = r_e_v;
    assign o_meta  = r_e_meta;
    assign o_value = r_e_value;

endmodule

@@ rtl/core/conv3x3_clamp_edge.sv @@
// 3x3 convolution over a raster pixel stream, borders clamped to the edge pixel.
// Input channel s_axis: one 8-bit pixel per item, frame in raster order.
// Output channel m_axis: one result per item; tdata carries row, column and the
// signed 28-bit sum, tlast ends the results caused by one input pixel and tuser
// flags the bottom right pixel of the frame.
// Configuration channel: index 0 width, 1 height, 2..4 kernel rows top to bottom
// (three signed 16-bit coefficients, left one in the low bits). Write only while
// the block is idle; cfg_ready is always high.
// A result is registered through stages a to e after the pixel that completes it.
// Throughput: one pixel per cycle on inner rows while m_axis does not stall; a
// row end pixel gives two results and a last-row pixel past column 0 two (the
// final pixel four), as the single multiply-add path takes one result per cycle.
// The line store is one 1024 x 16 RAM with registered read, two rows per word,
// read on accept and written back when stage a advances.
// Reset clears the counters, window and pipeline and loads the register reset
// values; the line store is not cleared and needs no clearing pass.
// When m_axis stalls, results queue in the four pipeline stages b to e, then
// stage a fills and tready on s_axis drops until space frees.
module conv3x3_clamp_edge (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  logic [7:0]                       i_s_axis_tdata,  // pixel
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    output logic [47:0]                      o_m_axis_tdata,  // out_row, out_col, value
    output logic                             o_m_axis_tlast,  // run_last
    output logic                             o_m_axis_tuser,  // frame_last
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [c3ce_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [c3ce_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import c3ce_pkg::*;

    logic [DIM_W-1:0]        r_width, r_height;
    t_krows                  r_krows;
    logic                    iss_valid, iss_ready;
    t_issue                  iss;
    t_meta                   res_meta;
    logic signed [VAL_W-1:0] res_value;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= DIM_W'(MAX_WIDTH);
            r_height <= DIM_W'(MAX_HEIGHT);
            r_krows  <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_WIDTH:    r_width    <= i_cfg_data[DIM_W-1:0];
                CFG_HEIGHT:   r_height   <= i_cfg_data[DIM_W-1:0];
                CFG_KROW_TOP: r_krows[0] <= i_cfg_data[KROW_W-1:0];
                CFG_KROW_MID: r_krows[1] <= i_cfg_data[KROW_W-1:0];
                CFG_KROW_BOT: r_krows[2] <= i_cfg_data[KROW_W-1:0];
                default: ;
            endcase
        end
    end

    c3ce_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .i_pixel     (i_s_axis_tdata),
        .i_width     (r_width),
        .i_height    (r_height),
        .o_iss_valid (iss_valid),
        .i_iss_ready (iss_ready),
        .o_iss       (iss)
    );

    c3ce_mac u_mac (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_iss_valid (iss_valid),
        .o_iss_ready (iss_ready),
        .i_iss       (iss),
        .i_krows     (r_krows),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_meta      (res_meta),
        .o_value     (res_value)
    );

    assign o_m_axis_tdata = {res_value, res_meta.col, res_meta.row};
    assign o_m_axis_tlast = res_meta.run_last;
    assign o_m_axis_tuser = res_meta.frame_last;

endmodule

@@ rtl/core/c3ce_checker.sv @@
module c3ce_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             o_m_axis_tvalid,
    input logic                             i_m_axis_tready,
    input logic [47:0]                      o_m_axis_tdata,
    input logic                             o_m_axis_tlast,
    input logic                             o_m_axis_tuser
);
    import c3ce_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast)
            && $stable(o_m_axis_tuser))
        else $error("result changed while stalled");

    // end of frame always closes its run
    a_frame_closes_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> o_m_axis_tlast)
        else $error("frame end without run end");

    // frame is at least 2x2, so its last pixel is never in row 0 or column 0
    a_frame_corner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |->
            (o_m_axis_tdata[OUT_RC_W-1:0] != '0)
            && (o_m_axis_tdata[2*OUT_RC_W-1:OUT_RC_W] != '0))
        else $error("frame end at row or column zero");

    // pipeline empties on reset
    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_m_axis_tvalid)
        else $error("result right after reset");

endmodule

bind conv3x3_clamp_edge c3ce_checker u_c3ce_checker (.*);
